### hw/rtl/pplc_pkg.sv
package pplc_pkg;

   // Position / sequencer mode, also the lock_mode code on the result channel
   typedef enum logic [2:0] {
      MODE_ENGAGED     = 3'd0,
      MODE_DISENGAGED  = 3'd1,
      MODE_ENGAGING    = 3'd2,
      MODE_DISENGAGING = 3'd3,
      MODE_FAULT       = 3'd4,
      MODE_INIT        = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      FLT_NONE        = 3'd0,
      FLT_SENSOR      = 3'd1,
      FLT_ENG_BLOCKED = 3'd2,
      FLT_ENG_TIMEOUT = 3'd3,
      FLT_REL_BLOCKED = 3'd4,
      FLT_REL_TIMEOUT = 3'd5
   } fault_type;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned SPEED_W = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MOVE_SPEED      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENGAGE_PULSE_TIME   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENGAGE_BUDGET_TIME  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_PULSE_TIME  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_BUDGET_TIME = 3'd4;

   // Calibration reset values
   localparam logic [SPEED_W-1:0] RST_MAX_MOVE_SPEED      = 16'd300;
   localparam logic [TIME_W-1:0]  RST_ENGAGE_PULSE_TIME   = 32'd200;
   localparam logic [TIME_W-1:0]  RST_ENGAGE_BUDGET_TIME  = 32'd500;
   localparam logic [TIME_W-1:0]  RST_RELEASE_PULSE_TIME  = 32'd200;
   localparam logic [TIME_W-1:0]  RST_RELEASE_BUDGET_TIME = 32'd500;

endpackage

### hw/rtl/pplc_req_if.sv
interface pplc_req_if;
   import pplc_pkg::*;

   logic               valid;
   logic               ready;
   logic [TIME_W-1:0]  time_now;
   logic               engaged_contact;
   logic               released_contact;
   logic [SPEED_W-1:0] vehicle_speed;
   logic               engage_req;

   modport source (
      output valid, time_now, engaged_contact, released_contact, vehicle_speed, engage_req,
      input  ready
   );
   modport sink (
      input  valid, time_now, engaged_contact, released_contact, vehicle_speed, engage_req,
      output ready
   );
endinterface

### hw/rtl/pplc_rsp_if.sv
interface pplc_rsp_if;
   logic       valid;
   logic       ready;
   logic       hold_drive;
   logic       release_drive;
   logic [2:0] lock_mode;
   logic [2:0] fault_code;
   logic       lock_engaged;

   modport source (
      output valid, hold_drive, release_drive, lock_mode, fault_code, lock_engaged,
      input  ready
   );
   modport sink (
      input  valid, hold_drive, release_drive, lock_mode, fault_code, lock_engaged,
      output ready
   );
endinterface

### hw/rtl/park_pawl_lock_controller_core.sv
// Park pawl lock controller. Each req item is one tick: millisecond timestamp,
// the two position contacts, vehicle speed and the driver's engage request;
// each tick yields exactly one rsp item with the solenoid drives, lock mode,
// sticky fault code and reported engaged status. Contacts both set or both
// clear give a sensor fault with both solenoids off. A position change is
// refused (blocked fault) above max_move_speed; otherwise the matching
// solenoid is pulsed for the pulse time and a timeout fault is raised once
// the budget has run out (elapsed time wraps modulo 2^32). The fault code
// clears only on reset. Throughput is one item per clock unless rsp stalls.
// An accepted item passes from the input register to the result register,
// which forms its rsp item; the two registers frame the 32-bit subtract and
// compares. A stalled rsp holds the result register; an empty input register
// still takes one more item before req ready drops. The user must write the
// calibration registers through the csr port only while no item is in flight,
// which the block does not enforce; writes past the last index are dropped.
module park_pawl_lock_controller_core (
   input  logic                               clock,
   input  logic                               reset,
   pplc_req_if.sink                           req_ch,
   pplc_rsp_if.source                         rsp_ch,
   input  logic                               csr_write_enable,
   input  logic [pplc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pplc_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import pplc_pkg::*;

   // ---------------- calibration registers ----------------
   logic [SPEED_W-1:0] max_speed_ff;
   logic [TIME_W-1:0]  eng_pulse_ff, eng_budget_ff, rel_pulse_ff, rel_budget_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff  <= RST_MAX_MOVE_SPEED;
         eng_pulse_ff  <= RST_ENGAGE_PULSE_TIME;
         eng_budget_ff <= RST_ENGAGE_BUDGET_TIME;
         rel_pulse_ff  <= RST_RELEASE_PULSE_TIME;
         rel_budget_ff <= RST_RELEASE_BUDGET_TIME;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_MOVE_SPEED:      max_speed_ff  <= csr_write_data[SPEED_W-1:0];
            CSR_ENGAGE_PULSE_TIME:   eng_pulse_ff  <= csr_write_data[TIME_W-1:0];
            CSR_ENGAGE_BUDGET_TIME:  eng_budget_ff <= csr_write_data[TIME_W-1:0];
            CSR_RELEASE_PULSE_TIME:  rel_pulse_ff  <= csr_write_data[TIME_W-1:0];
            CSR_RELEASE_BUDGET_TIME: rel_budget_ff <= csr_write_data[TIME_W-1:0];
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   // ---------------- handshake / pipeline control ----------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff;
   logic advance;     // result register can take the item in stage 1
   logic req_fire;

   assign advance      = !s2_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_fire || (s1_valid_ff && !advance);

   // ---------------- input register ----------------
   logic [TIME_W-1:0]  s1_now_ff;
   logic               s1_eng_ff, s1_rel_ff, s1_want_ff;
   logic [SPEED_W-1:0] s1_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_now_ff   <= req_ch.time_now;
         s1_eng_ff   <= req_ch.engaged_contact;
         s1_rel_ff   <= req_ch.released_contact;
         s1_speed_ff <= req_ch.vehicle_speed;
         s1_want_ff  <= req_ch.engage_req;
      end
   end

   // ---------------- controller state ----------------
   mode_type          mode_ff, mode_in;
   fault_type         fault_ff, fault_in;
   logic [TIME_W-1:0] start_ff, start_in;

   // ---------------- tick evaluation ----------------
   mode_type          observed, mode_cur, move_mode;
   logic [TIME_W-1:0] elapsed, pulse_time, budget_time;
   logic              contacts_bad, at_rest, slow_enough, pulse, timed_out;
   logic              hold_in, rel_drv_in, engaged_in;

   // shared terms: observed position, phase start, elapsed time
   always_comb begin
      contacts_bad = (s1_eng_ff == s1_rel_ff);
      at_rest      = (s1_want_ff == s1_eng_ff);
      observed     = s1_eng_ff ? MODE_ENGAGED : MODE_DISENGAGED;
      mode_cur     = (mode_ff == MODE_INIT) ? observed : mode_ff;
      move_mode    = s1_want_ff ? MODE_ENGAGING : MODE_DISENGAGING;
      pulse_time   = s1_want_ff ? eng_pulse_ff : rel_pulse_ff;
      budget_time  = s1_want_ff ? eng_budget_ff : rel_budget_ff;
      slow_enough  = (s1_speed_ff <= max_speed_ff);  // equal speed still moves
      start_in     = start_ff;
      if (!contacts_bad) begin
         // first good reading, or a move entering its phase, restarts the clock
         if (mode_ff == MODE_INIT || (!at_rest && slow_enough && mode_cur != move_mode)) begin
            start_in = s1_now_ff;
         end
      end
      elapsed   = s1_now_ff - start_in;  // wraps mod 2^32
      pulse     = (elapsed < pulse_time);
      timed_out = !pulse && (elapsed >= budget_time);
   end

   // next mode and sticky fault
   always_comb begin
      mode_in  = mode_ff;
      fault_in = fault_ff;
      if (contacts_bad) begin
         // contacts disagree with any real position
         fault_in = FLT_SENSOR;
         mode_in  = MODE_FAULT;
      end else if (at_rest) begin
         // at rest in requested position
         mode_in = observed;
      end else if (!slow_enough) begin
         // move refused, pawl stays where it is
         fault_in = s1_want_ff ? FLT_ENG_BLOCKED : FLT_REL_BLOCKED;
         mode_in  = observed;
      end else if (timed_out) begin
         fault_in = s1_want_ff ? FLT_ENG_TIMEOUT : FLT_REL_TIMEOUT;
         mode_in  = observed;
      end else begin
         mode_in = move_mode;
      end
   end

   // solenoid drives and reported position
   always_comb begin
      hold_in    = 1'b0;
      rel_drv_in = 1'b0;
      engaged_in = 1'b0;
      if (!contacts_bad) begin
         // engaging starts from released, releasing from engaged
         engaged_in = s1_eng_ff;
         if (!at_rest && slow_enough && !timed_out) begin
            hold_in    = s1_want_ff && pulse;
            rel_drv_in = !s1_want_ff && pulse;
         end
      end
   end

   // state commits when the item moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_INIT;
         fault_ff <= FLT_NONE;
         start_ff <= '0;
      end else if (s1_valid_ff && advance) begin
         mode_ff  <= mode_in;
         fault_ff <= fault_in;
         start_ff <= start_in;
      end
   end

   // ---------------- result register ----------------
   logic       hold_ff, rel_drv_ff, engaged_ff;
   logic [2:0] lock_mode_ff, fault_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && advance) begin
         hold_ff       <= hold_in;
         rel_drv_ff    <= rel_drv_in;
         engaged_ff    <= engaged_in;
         lock_mode_ff  <= 3'(mode_in);
         fault_code_ff <= 3'(fault_in);
      end
   end

   assign rsp_ch.valid         = s2_valid_ff;
   assign rsp_ch.hold_drive    = hold_ff;
   assign rsp_ch.release_drive = rel_drv_ff;
   assign rsp_ch.lock_mode     = lock_mode_ff;
   assign rsp_ch.fault_code    = fault_code_ff;
   assign rsp_ch.lock_engaged  = engaged_ff;

endmodule
